@@ hw/rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Types, constants and round functions shared by the digest core and its
// stream interfaces.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_hash;
    typedef logic [6:0]       t_round;

    // One message item on the input channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_item;

    // One digest word on the output channel
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_EMIT
    } t_state;

    localparam t_word C_IV0 = 32'h6745_2301;
    localparam t_word C_IV1 = 32'hEFCD_AB89;
    localparam t_word C_IV2 = 32'h98BA_DCFE;
    localparam t_word C_IV3 = 32'h1032_5476;
    localparam t_word C_IV4 = 32'hC3D2_E1F0;
    localparam t_hash C_IV  = {C_IV4, C_IV3, C_IV2, C_IV1, C_IV0};

    localparam t_word C_K0 = 32'h5A82_7999;
    localparam t_word C_K1 = 32'h6ED9_EBA1;
    localparam t_word C_K2 = 32'h8F1B_BCDC;
    localparam t_word C_K3 = 32'hCA62_C1D6;

    localparam logic [7:0] C_PAD_MARK  = 8'h80;
    localparam logic [7:0] C_PAD_ZERO  = 8'h00;
    localparam logic [5:0] C_FILL_FULL = 6'd63;   // fill before the block's last byte
    localparam logic [5:0] C_FILL_LEN  = 6'd56;   // fill where the length field starts

    localparam t_round C_SCHED_LOAD = 7'd16;
    localparam t_round C_PHASE1     = 7'd20;
    localparam t_round C_PHASE2     = 7'd40;
    localparam t_round C_PHASE3     = 7'd60;
    localparam t_round C_LAST_ROUND = 7'd79;
    localparam t_round C_LAST_LEN   = 7'd7;
    localparam t_round C_LAST_WORD  = 7'd4;

    function automatic t_word sha1_f(input t_round t, input t_word b, input t_word c,
                                     input t_word d);
        t_word res;
        if (t < C_PHASE1) begin
            res = (b & c) | (~b & d);
        end else if (t < C_PHASE2) begin
            res = b ^ c ^ d;
        end else if (t < C_PHASE3) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic t_word sha1_k(input t_round t);
        t_word res;
        if (t < C_PHASE1) begin
            res = C_K0;
        end else if (t < C_PHASE2) begin
            res = C_K1;
        end else if (t < C_PHASE3) begin
            res = C_K2;
        end else begin
            res = C_K3;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/sha1_in_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message stream interface
// Valid/ready channel carrying one message item per transfer.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic              valid;
    logic              ready;
    sha1_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/sha1_out_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest stream interface
// Valid/ready channel carrying one digest word per transfer.
// ----------------------------------------------------------------------------
interface sha1_out_if;
    logic               valid;
    logic               ready;
    sha1_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/sha1_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte-stream SHA-1 with one shared round unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Message bytes enter one per transfer on i_msg and are packed big-endian
// into a 512-bit block shift register. A byte that does not complete a
// block leaves the core ready for the next. The 64th byte of a block starts
// the compression: the one round unit runs 80 rounds, one a cycle, and a
// fold step then adds the result into the chaining words. The compression
// loop is what sets the rate. An item marked last starts padding: the
// marker byte, zeros and the eight length bytes go through the same byte
// path at one a cycle, with a step that writes no byte between the last
// zero and the first length byte, and with one or two compressions on the
// way, after which the five digest words leave on o_dig, word 0 (most
// significant) first, one per transfer. The core takes no new item from the
// end of a block until its compression is done, nor from a last item until
// the fifth digest word has been taken; after that a new message starts
// from the initial chaining values. An item without a byte and without the
// last mark is taken and changes nothing.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_msg,
    sha1_out_if.source        o_dig
);

    // Sequencer and chaining state
    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_state r_ret,   n_ret;     // where to go once a compression is folded in
    sha1_pkg::t_round r_cnt,   n_cnt;     // round, length byte or digest word count
    logic [5:0]       r_fill,  n_fill;
    logic [63:0]      r_len,   n_len;
    sha1_pkg::t_hash  r_h,     n_h;

    // Block buffer, reused as the rolling schedule window during rounds
    logic [511:0]     r_blk,   n_blk;
    sha1_pkg::t_word  r_a, r_b, r_c, r_d, r_e;
    sha1_pkg::t_word  n_a, n_b, n_c, n_d, n_e;

    // Byte path shared by message and padding bytes
    logic             w_byte_we;
    logic [7:0]       w_byte;

    // Round unit
    sha1_pkg::t_word  w_win0, w_win2, w_win8, w_win13;
    sha1_pkg::t_word  w_mix, w_sched, w_f, w_k, w_tmp;

    // Window taps: word 0 is the oldest schedule word W[t-16]
    assign w_win0  = r_blk[511:480];
    assign w_win2  = r_blk[447:416];
    assign w_win8  = r_blk[255:224];
    assign w_win13 = r_blk[95:64];

    assign w_mix   = w_win13 ^ w_win8 ^ w_win2 ^ w_win0;
    assign w_sched = (r_cnt < sha1_pkg::C_SCHED_LOAD) ? w_win0 : {w_mix[30:0], w_mix[31]};
    assign w_f     = sha1_pkg::sha1_f(r_cnt, r_b, r_c, r_d);
    assign w_k     = sha1_pkg::sha1_k(r_cnt);
    assign w_tmp   = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_sched + w_k;

    // Digest word presented straight from the chaining registers
    assign o_dig.data.digest_word = r_h[r_cnt[2:0]];
    assign o_dig.data.word_index  = r_cnt[2:0];
    assign o_dig.data.last_word   = (r_cnt == sha1_pkg::C_LAST_WORD);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_len     = r_len;
        n_h       = r_h;
        n_blk     = r_blk;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_e       = r_e;
        w_byte_we = 1'b0;
        w_byte    = sha1_pkg::C_PAD_ZERO;
        i_msg.ready = 1'b0;
        o_dig.valid = 1'b0;

        unique case (r_state)
            sha1_pkg::S_IDLE: begin
                i_msg.ready = 1'b1;
                if (i_msg.valid) begin
                    if (i_msg.data.has_byte) begin
                        w_byte_we = 1'b1;
                        w_byte    = i_msg.data.data_byte;
                        n_len     = r_len + 64'd8;
                    end
                    if (i_msg.data.is_last) begin
                        n_state = sha1_pkg::S_PAD_MARK;
                    end
                end
            end
            sha1_pkg::S_ROUND: begin
                // advance one round and roll the schedule window
                n_blk = {r_blk[479:0], w_sched};
                n_e   = r_d;
                n_d   = r_c;
                n_c   = {r_b[1:0], r_b[31:2]};
                n_b   = r_a;
                n_a   = w_tmp;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == sha1_pkg::C_LAST_ROUND) begin
                    n_state = sha1_pkg::S_FOLD;
                end
            end
            sha1_pkg::S_FOLD: begin
                n_h[0]  = r_h[0] + r_a;
                n_h[1]  = r_h[1] + r_b;
                n_h[2]  = r_h[2] + r_c;
                n_h[3]  = r_h[3] + r_d;
                n_h[4]  = r_h[4] + r_e;
                n_cnt   = '0;
                n_state = r_ret;
            end
            sha1_pkg::S_PAD_MARK: begin
                w_byte_we = 1'b1;
                w_byte    = sha1_pkg::C_PAD_MARK;
                n_state   = sha1_pkg::S_PAD_ZERO;
            end
            sha1_pkg::S_PAD_ZERO: begin
                if (r_fill == sha1_pkg::C_FILL_LEN) begin
                    n_cnt   = '0;
                    n_state = sha1_pkg::S_PAD_LEN;
                end else begin
                    w_byte_we = 1'b1;
                end
            end
            sha1_pkg::S_PAD_LEN: begin
                // length goes out most significant byte first
                w_byte_we = 1'b1;
                w_byte    = r_len[63:56];
                n_len     = {r_len[55:0], 8'h00};
                n_cnt     = r_cnt + 7'd1;
                if (r_cnt == sha1_pkg::C_LAST_LEN) begin
                    n_state = sha1_pkg::S_EMIT;
                end
            end
            sha1_pkg::S_EMIT: begin
                o_dig.valid = 1'b1;
                if (o_dig.ready) begin
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt == sha1_pkg::C_LAST_WORD) begin
                        // drop back to a fresh message
                        n_h     = sha1_pkg::C_IV;
                        n_fill  = '0;
                        n_len   = '0;
                        n_cnt   = '0;
                        n_state = sha1_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::S_IDLE;
            end
        endcase

        // Shift the byte in; a completed block diverts to the round unit and
        // resumes at the state chosen above once folded in.
        if (w_byte_we) begin
            n_blk  = {r_blk[503:0], w_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == sha1_pkg::C_FILL_FULL) begin
                n_ret   = n_state;
                n_state = sha1_pkg::S_ROUND;
                n_cnt   = '0;
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_e     = r_h[4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::S_IDLE;
            r_ret   <= sha1_pkg::S_IDLE;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_len   <= '0;
            r_h     <= sha1_pkg::C_IV;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_h     <= n_h;
        end
    end

    // Payload: block buffer and round variables need no reset
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

endmodule
